// ===== hw/rtl/mfb_pkg.sv =====
// Package for the monochrome framebuffer blitter: operation codes, register
// indexes, lane count and the lane result type. No dependencies.
package mfb_pkg;

    localparam int LANES   = 8;   // one lane per bit of a bitmap byte
    localparam int COLB_W  = 5;   // column byte within a page row (up to 256 columns)
    localparam int PAGE_W  = 4;   // page number (up to 128 rows)
    localparam int CFG_AW  = 3;
    localparam int CFG_DW  = 9;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_PIXEL  = 2'd1,
        OP_BITMAP = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    localparam logic [CFG_AW-1:0] REG_BLIT_X      = 3'd0;
    localparam logic [CFG_AW-1:0] REG_BLIT_Y      = 3'd1;
    localparam logic [CFG_AW-1:0] REG_BLIT_WIDTH  = 3'd2;
    localparam logic [CFG_AW-1:0] REG_BLIT_HEIGHT = 3'd3;
    localparam logic [CFG_AW-1:0] REG_BLIT_COLOR  = 3'd4;

    typedef struct packed {
        logic              hit;
        logic [COLB_W-1:0] col_byte;
    } t_lane_hit;

endpackage

// ===== hw/rtl/mfb_ram.sv =====
// Generic simple dual-port RAM with registered read.
// No dependencies.
module mfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== hw/rtl/mfb_lane.sv =====
// One bitmap lane: decides whether one bitmap bit lands on the screen and
// in which column byte. Depends on mfb_pkg.
module mfb_lane #(
    parameter int SCREEN_WIDTH = 128,
    parameter int LANE         = 0
) (
    input  logic signed [10:0]          i_x_base,   // blit_x plus first pixel of this byte
    input  logic [mfb_pkg::COLB_W-1:0]  i_col_byte, // byte index within the bitmap row
    input  logic [7:0]                  i_width,
    input  logic                        i_bit,
    input  logic                        i_row_ok,
    output mfb_pkg::t_lane_hit          o_hit
);
    logic [7:0]         w_idx;
    logic signed [10:0] w_x;

    assign w_idx = {i_col_byte, 3'(LANE)};
    assign w_x   = i_x_base + 11'(LANE);

    assign o_hit.hit = i_bit && i_row_ok && (w_idx < i_width) && !w_x[10]
                       && (w_x < 11'(SCREEN_WIDTH));
    assign o_hit.col_byte = w_x[7:3];
endmodule

// ===== hw/rtl/mfb_merge.sv =====
// Routes the eight lane results onto the eight column banks and forms each
// bank's byte address. Depends on mfb_pkg.
module mfb_merge #(
    parameter int COL_BYTES = 16,
    parameter int BANK_AW   = 7
) (
    input  mfb_pkg::t_lane_hit           i_lanes [mfb_pkg::LANES],
    input  logic [2:0]                   i_offset,  // column of lane 0 modulo eight
    input  logic [mfb_pkg::PAGE_W-1:0]   i_page,
    output logic [mfb_pkg::LANES-1:0]    o_en,
    output logic [BANK_AW-1:0]           o_addr [mfb_pkg::LANES]
);
    // Eight consecutive columns fall in eight different banks, so each bank
    // takes exactly one lane.
    always_comb begin
        for (int b = 0; b < mfb_pkg::LANES; b++) begin
            logic [2:0] l;
            l         = 3'(b) - i_offset;
            o_en[b]   = i_lanes[l].hit;
            o_addr[b] = BANK_AW'(int'(i_page) * COL_BYTES + int'(i_lanes[l].col_byte));
        end
    end
endmodule

// ===== hw/rtl/monochrome_framebuffer_blitter.sv =====
// Top level of the monochrome framebuffer blitter: eight column banks, bitmap
// lanes, lane merge and control. Depends on mfb_pkg, mfb_ram, mfb_lane, mfb_merge.
//
//  channel   direction  handshake                        payload
//  s_axis    in         i_s_axis_tvalid/o_s_axis_tready  tdata fields, tuser op
//  m_axis    out        o_m_axis_tvalid/i_m_axis_tready  tdata read_data, tlast blit_done
//  cfg       in         i_cfg_valid/o_cfg_ready          i_cfg_index, i_cfg_data
//
// Pixel, bitmap byte and read each pass through accept, bank read, and bank
// write or capture, an order set by read-modify-write on registered-read banks.
// Clear sweeps all banks together, one row address a cycle, over each bank's
// PAGES * ceil(W/8) addresses. The same pass runs after reset, and no item is
// accepted meanwhile. An item is taken only while the result register is empty
// or being emptied.
module monochrome_framebuffer_blitter #(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [7:0] pixel_x, [15:8] pixel_y, [16] pixel_color, [24:17] bitmap_byte,
    // [34:25] read_index, [39:35] zero
    input  logic [39:0] i_s_axis_tdata,
    input  logic [1:0]  i_s_axis_tuser,  // [1:0] op
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,  // [7:0] read_data
    output logic        o_m_axis_tlast,  // blit_done
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [mfb_pkg::CFG_AW-1:0] i_cfg_index,
    input  logic [mfb_pkg::CFG_DW-1:0] i_cfg_data
);
    localparam int PAGES       = (SCREEN_HEIGHT + 7) / 8;
    localparam int COL_BYTES   = (SCREEN_WIDTH + 7) / 8;
    localparam int BANK_DEPTH  = PAGES * COL_BYTES;
    localparam int BANK_AW     = BANK_DEPTH > 1 ? $clog2(BANK_DEPTH) : 1;
    localparam int STORE_BYTES = SCREEN_WIDTH * PAGES;

    typedef enum logic [1:0] {S_IDLE, S_RD, S_WR, S_CLR} t_state;

    t_state r_state;

    logic signed [8:0] r_bx, r_by;
    logic [7:0]        r_bw, r_bh;
    logic              r_bc;
    logic [mfb_pkg::COLB_W-1:0] r_cb;
    logic [7:0]        r_row;

    mfb_pkg::t_op      r_op;
    logic [7:0]        r_en;
    logic [BANK_AW-1:0] r_addr [mfb_pkg::LANES];
    logic [7:0]        r_mask;
    logic              r_color;
    logic              r_done;
    logic [9:0]        r_ridx;
    logic [mfb_pkg::PAGE_W-1:0] r_rpage;
    logic              r_rvalid;
    logic [2:0]        r_rbank;
    logic [BANK_AW-1:0] r_clr;
    logic              r_ovalid;
    logic [7:0]        r_odata;
    logic              r_olast;

    // input fields
    mfb_pkg::t_op w_op;
    logic [7:0]   w_px, w_py, w_bmp;
    logic         w_pcol;
    logic [9:0]   w_idx;
    logic         w_acc;

    assign w_op   = mfb_pkg::t_op'(i_s_axis_tuser);
    assign w_px   = i_s_axis_tdata[7:0];
    assign w_py   = i_s_axis_tdata[15:8];
    assign w_pcol = i_s_axis_tdata[16];
    assign w_bmp  = i_s_axis_tdata[24:17];
    assign w_idx  = i_s_axis_tdata[34:25];

    assign o_s_axis_tready = (r_state == S_IDLE) && (!r_ovalid || i_m_axis_tready);
    assign w_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;

    // Bitmap geometry of the current byte.
    logic signed [10:0] w_xbase, w_y;
    logic               w_row_ok;

    assign w_xbase  = $signed({{2{r_bx[8]}}, r_bx}) + $signed({3'b000, r_cb, 3'b000});
    assign w_y      = $signed({{2{r_by[8]}}, r_by}) + $signed({3'b000, r_row});
    assign w_row_ok = (r_bh != 8'd0) && !w_y[10] && (w_y < 11'(SCREEN_HEIGHT));

    mfb_pkg::t_lane_hit w_lanes [mfb_pkg::LANES];
    logic [7:0]         w_ben;
    logic [BANK_AW-1:0] w_baddr [mfb_pkg::LANES];

    for (genvar k = 0; k < mfb_pkg::LANES; k++) begin : g_lane
        mfb_lane #(
            .SCREEN_WIDTH (SCREEN_WIDTH),
            .LANE         (k)
        ) u_lane (
            .i_x_base   (w_xbase),
            .i_col_byte (r_cb),
            .i_width    (r_bw),
            .i_bit      (w_bmp[7-k]),
            .i_row_ok   (w_row_ok),
            .o_hit      (w_lanes[k])
        );
    end

    mfb_merge #(
        .COL_BYTES (COL_BYTES),
        .BANK_AW   (BANK_AW)
    ) u_merge (
        .i_lanes  (w_lanes),
        .i_offset (w_xbase[2:0]),
        .i_page   (w_y[6:3]),
        .o_en     (w_ben),
        .o_addr   (w_baddr)
    );

    // Single pixel.
    logic               w_pix_ok;
    logic [BANK_AW-1:0] w_pix_addr;

    assign w_pix_ok   = ({1'b0, w_px} < 9'(SCREEN_WIDTH)) && ({1'b0, w_py} < 9'(SCREEN_HEIGHT));
    assign w_pix_addr = BANK_AW'(int'(w_py[6:3]) * COL_BYTES + int'(w_px[7:3]));

    // Blit progress after this byte.
    logic [5:0] w_row_bytes, w_cb_inc;
    logic [8:0] w_row_inc;
    logic       w_empty, w_row_end, w_last;

    assign w_row_bytes = 6'(({1'b0, r_bw} + 9'd7) >> 3);
    assign w_cb_inc    = {1'b0, r_cb} + 6'd1;
    assign w_row_inc   = {1'b0, r_row} + 9'd1;
    assign w_empty     = (r_bw == 8'd0) || (r_bh == 8'd0);
    assign w_row_end   = w_cb_inc >= w_row_bytes;
    assign w_last      = w_empty || (w_row_end && (w_row_inc >= {1'b0, r_bh}));

    // Read address: page by comparison against each page start.
    logic [12:0]                w_idx_ext;
    logic [mfb_pkg::PAGE_W-1:0] w_rpage;
    logic [7:0]                 w_rcol;
    logic [BANK_AW-1:0]         w_raddr;

    assign w_idx_ext = {3'b000, w_idx};
    always_comb begin
        w_rpage = '0;
        for (int p = 1; p < PAGES; p++) begin
            w_rpage = w_rpage + mfb_pkg::PAGE_W'(w_idx_ext >= 13'(p * SCREEN_WIDTH));
        end
    end
    assign w_rcol  = 8'(int'(r_ridx) - int'(r_rpage) * SCREEN_WIDTH);
    assign w_raddr = BANK_AW'(int'(r_rpage) * COL_BYTES + int'(w_rcol[7:3]));

    // Banks
    logic               w_we    [mfb_pkg::LANES];
    logic [BANK_AW-1:0] w_wa    [mfb_pkg::LANES];
    logic [7:0]         w_wd    [mfb_pkg::LANES];
    logic [BANK_AW-1:0] w_ra    [mfb_pkg::LANES];
    logic [7:0]         w_rdata [mfb_pkg::LANES];

    for (genvar b = 0; b < mfb_pkg::LANES; b++) begin : g_bank
        always_comb begin
            if (r_state == S_CLR) begin
                w_we[b] = 1'b1;
                w_wa[b] = r_clr;
                w_wd[b] = 8'd0;
            end else begin
                w_we[b] = (r_state == S_WR) && r_en[b] && (r_op != mfb_pkg::OP_READ);
                w_wa[b] = r_addr[b];
                w_wd[b] = r_color ? (w_rdata[b] | r_mask) : (w_rdata[b] & ~r_mask);
            end
            w_ra[b] = (r_op == mfb_pkg::OP_READ) ? w_raddr : r_addr[b];
        end

        mfb_ram #(
            .WIDTH (8),
            .DEPTH (BANK_DEPTH)
        ) u_bank (
            .i_clk   (i_clk),
            .i_we    (w_we[b]),
            .i_waddr (w_wa[b]),
            .i_wdata (w_wd[b]),
            .i_raddr (w_ra[b]),
            .o_rdata (w_rdata[b])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
            r_bx     <= '0;
            r_by     <= '0;
            r_bw     <= '0;
            r_bh     <= '0;
            r_bc     <= 1'b1;
            r_cb     <= '0;
            r_row    <= '0;
            r_op     <= mfb_pkg::OP_CLEAR;
        end else begin
            if (r_ovalid && i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end

            if (i_cfg_valid && o_cfg_ready && (i_cfg_index <= mfb_pkg::REG_BLIT_COLOR)) begin
                case (i_cfg_index)
                    mfb_pkg::REG_BLIT_X:      r_bx <= $signed(i_cfg_data);
                    mfb_pkg::REG_BLIT_Y:      r_by <= $signed(i_cfg_data);
                    mfb_pkg::REG_BLIT_WIDTH:  r_bw <= i_cfg_data[7:0];
                    mfb_pkg::REG_BLIT_HEIGHT: r_bh <= i_cfg_data[7:0];
                    default:                  r_bc <= i_cfg_data[0];
                endcase
                r_cb  <= '0;
                r_row <= '0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_op <= w_op;
                        case (w_op)
                            mfb_pkg::OP_CLEAR: begin
                                r_clr   <= '0;
                                r_state <= S_CLR;
                            end
                            mfb_pkg::OP_PIXEL: begin
                                for (int b = 0; b < mfb_pkg::LANES; b++) begin
                                    r_en[b]   <= w_pix_ok && (w_px[2:0] == 3'(b));
                                    r_addr[b] <= w_pix_addr;
                                end
                                r_mask  <= 8'd1 << w_py[2:0];
                                r_color <= w_pcol;
                                r_state <= S_RD;
                            end
                            mfb_pkg::OP_BITMAP: begin
                                r_en    <= w_ben;
                                r_addr  <= w_baddr;
                                r_mask  <= 8'd1 << w_y[2:0];
                                r_color <= r_bc;
                                r_done  <= w_last;
                                if (w_empty || w_last) begin
                                    r_cb  <= '0;
                                    r_row <= '0;
                                end else if (w_row_end) begin
                                    r_cb  <= '0;
                                    r_row <= w_row_inc[7:0];
                                end else begin
                                    r_cb  <= w_cb_inc[mfb_pkg::COLB_W-1:0];
                                end
                                r_state <= S_RD;
                            end
                            default: begin
                                r_en     <= '0;
                                r_ridx   <= w_idx;
                                r_rpage  <= w_rpage;
                                r_rvalid <= w_idx_ext < 13'(STORE_BYTES);
                                r_state  <= S_RD;
                            end
                        endcase
                    end
                end
                S_RD: begin
                    r_rbank <= w_rcol[2:0];
                    r_state <= S_WR;
                end
                S_WR: begin
                    if (r_op == mfb_pkg::OP_READ) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= r_rvalid ? w_rdata[r_rbank] : 8'd0;
                        r_olast  <= 1'b0;
                    end else if (r_op == mfb_pkg::OP_BITMAP) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= 8'd0;
                        r_olast  <= r_done;
                    end
                    r_state <= S_IDLE;
                end
                S_CLR: begin
                    r_clr <= r_clr + BANK_AW'(1);
                    if (r_clr == BANK_AW'(BANK_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tlast  = r_olast;

`ifndef ASSERT_OFF
    a_out_from_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state) == S_WR)
        else $error("result appeared outside the write step");

    a_no_take_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |-> !o_s_axis_tready)
        else $error("item taken during clearing pass");

    a_row_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_row == 8'd0) || (r_row < r_bh))
        else $error("bitmap row beyond configured height");

    a_read_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR && r_op == mfb_pkg::OP_READ) |-> (r_en == 8'd0))
        else $error("read item would modify the store");
`endif

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for monochrome_framebuffer_blitter: directed tables, then
// random bitmap blits, pixels, reads and clears checked against an in-bench predictor.
// Depends on mfb_pkg and the blitter RTL only.
`timescale 1ns / 1ps

module tb_top;

    localparam int SCR_W     = 128;
    localparam int SCR_H     = 64;
    localparam int FB_BYTES  = SCR_W * ((SCR_H + 7) / 8);
    localparam int RANDOM_ITEMS = 600;
    localparam int SETTLE_CYCLES = 200;   // margin for a clear sweep plus pipeline
    localparam int LONG_HOLD  = 300;
    localparam logic [mfb_pkg::CFG_AW-1:0] REG_UNUSED_LO = 3'd5;
    localparam logic [mfb_pkg::CFG_AW-1:0] REG_UNUSED_HI = 3'd7;

    typedef struct {
        logic [7:0] read_data;
        logic       blit_done;
    } t_fb_result;

    typedef struct {
        mfb_pkg::t_op op;
        logic [7:0] x;
        logic [7:0] y;
        logic       color;
        logic [7:0] bm_byte;
        logic [9:0] index;
        bit         typed;
        logic [7:0] want_data;
        logic       want_done;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [mfb_pkg::CFG_AW-1:0] cfg_index = '0;
    logic [mfb_pkg::CFG_DW-1:0] cfg_data = '0;

    always #1 i_clk = ~i_clk;

    monochrome_framebuffer_blitter u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    // Predicted frame store, blit registers and blit progress.
    logic [7:0]        fb_mirror [FB_BYTES];
    logic signed [8:0] pos_x, pos_y;
    logic [7:0]        bm_width, bm_height;
    logic              bm_color;
    int                col_byte, bm_row;

    t_fb_result result_q [$];
    int n_errors, n_items, n_results, n_blits;
    int rx_mode;
    bit long_hold_req;
    bit sender_steady;

    task automatic report(input string what, input int got, input int want);
        $display("mismatch: %s got 0x%0h expected 0x%0h at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    function automatic void plot(input int px, input int py, input logic colour);
        int addr;
        if (px < 0 || px >= SCR_W || py < 0 || py >= SCR_H) return;
        addr = (py / 8) * SCR_W + px;
        fb_mirror[addr][py % 8] = colour;
    endfunction

    // Applies one item to the predicted state; returns 1 when a result is due.
    function automatic bit predict_item(input mfb_pkg::t_op op, input logic [7:0] x,
                                        input logic [7:0] y, input logic colour,
                                        input logic [7:0] data, input logic [9:0] index,
                                        output t_fb_result res);
        int row_bytes, pix;
        res = '{8'h00, 1'b0};
        case (op)
            mfb_pkg::OP_CLEAR: begin
                foreach (fb_mirror[a]) fb_mirror[a] = 8'h00;
                return 0;
            end
            mfb_pkg::OP_PIXEL: begin
                plot(int'(x), int'(y), colour);
                return 0;
            end
            mfb_pkg::OP_READ: begin
                res.read_data = (int'(index) < FB_BYTES) ? fb_mirror[index] : 8'h00;
                return 1;
            end
            default: begin
                if (bm_width == 8'd0 || bm_height == 8'd0) begin
                    col_byte = 0;
                    bm_row = 0;
                    res.blit_done = 1'b1;
                    return 1;
                end
                row_bytes = (int'(bm_width) + 7) / 8;
                for (int k = 0; k < 8; k++) begin
                    pix = col_byte * 8 + k;
                    if (pix < int'(bm_width) && data[7-k])
                        plot(int'(pos_x) + pix, int'(pos_y) + bm_row, bm_color);
                end
                col_byte++;
                if (col_byte >= row_bytes) begin
                    col_byte = 0;
                    bm_row++;
                    if (bm_row >= int'(bm_height)) begin
                        bm_row = 0;
                        res.blit_done = 1'b1;
                    end
                end
                return 1;
            end
        endcase
    endfunction

    task automatic write_reg(input logic [mfb_pkg::CFG_AW-1:0] idx,
                             input logic [mfb_pkg::CFG_DW-1:0] value);
        @(negedge i_clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        forever begin
            @(posedge i_clk);
            if (cfg_ready) break;
        end
        @(negedge i_clk);
        cfg_valid = 1'b0;
        cfg_index = mfb_pkg::CFG_AW'($urandom);
        cfg_data  = mfb_pkg::CFG_DW'($urandom);
        case (idx)
            mfb_pkg::REG_BLIT_X:      pos_x = value;
            mfb_pkg::REG_BLIT_Y:      pos_y = value;
            mfb_pkg::REG_BLIT_WIDTH:  bm_width = value[7:0];
            mfb_pkg::REG_BLIT_HEIGHT: bm_height = value[7:0];
            mfb_pkg::REG_BLIT_COLOR:  bm_color = value[0];
            default:                  return;
        endcase
        col_byte = 0;
        bm_row = 0;
    endtask

    task automatic setup_blit(input int x, input int y, input int w, input int h, input bit c);
        write_reg(mfb_pkg::REG_BLIT_X, 9'(x));
        write_reg(mfb_pkg::REG_BLIT_Y, 9'(y));
        write_reg(mfb_pkg::REG_BLIT_WIDTH, 9'(w));
        write_reg(mfb_pkg::REG_BLIT_HEIGHT, 9'(h));
        write_reg(mfb_pkg::REG_BLIT_COLOR, {8'($urandom_range(0, 255)), c});
        write_reg(3'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)), 9'($urandom));
    endtask

    // Offers one item and waits for its transfer; the expectation is queued first.
    task automatic send_item(input t_row r);
        t_fb_result res;
        if (predict_item(r.op, r.x, r.y, r.color, r.bm_byte, r.index, res)) begin
            if (r.typed) res = '{r.want_data, r.want_done};
            result_q.push_back(res);
        end
        @(negedge i_clk);
        s_tvalid = 1'b1;
        s_tuser  = r.op;
        s_tdata  = {5'b0, r.index, r.bm_byte, r.color, r.y, r.x};
        forever begin
            @(posedge i_clk);
            if (s_tready) break;
        end
        n_items++;
    endtask

    task automatic sender_gap(input int cycles);
        @(negedge i_clk);
        s_tvalid = 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    task automatic drain();
        sender_gap(0);
        while (result_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_row noise_row(input mfb_pkg::t_op op);
        t_row r;
        r.op = op;
        r.x = 8'($urandom);
        r.y = 8'($urandom);
        r.color = 1'($urandom);
        r.bm_byte = 8'($urandom);
        r.index = 10'($urandom);
        r.typed = 0;
        r.want_data = '0;
        r.want_done = 1'b0;
        if (op == mfb_pkg::OP_PIXEL && $urandom_range(0, 3) != 0) begin
            r.x = 8'($urandom_range(0, SCR_W - 1));
            r.y = 8'($urandom_range(0, SCR_H - 1));
        end
        return r;
    endfunction

    // Result side: ready follows the current mode; a long hold-off on request.
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                m_tready = 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                long_hold_req = 0;
            end else begin
                case (rx_mode)
                    0: m_tready = 1'b1;
                    1: m_tready = ($urandom_range(0, 3) != 0);
                    default: begin
                        if (stall_left > 0) begin
                            stall_left--;
                            m_tready = 1'b0;
                        end else begin
                            m_tready = 1'b1;
                            if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 12);
                        end
                    end
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        t_fb_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (result_q.size() == 0) begin
                report("unexpected result", int'(m_tdata), 0);
            end else begin
                want = result_q.pop_front();
                n_results++;
                if (m_tdata !== want.read_data)
                    report("read_data", int'(m_tdata), int'(want.read_data));
                if (m_tlast !== want.blit_done)
                    report("blit_done", int'(m_tlast), int'(want.blit_done));
                if (want.blit_done) n_blits++;
            end
        end
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d results outstanding", result_q.size());
        $display("*** FAILED ***");
        $finish;
    end

    t_row reset_rows [] = '{
        '{mfb_pkg::OP_READ,   8'd0,   8'd0,   1'b0, 8'h00, 10'd0,    1, 8'h00, 1'b0},
        '{mfb_pkg::OP_READ,   8'd0,   8'd0,   1'b0, 8'h00, 10'd1023, 1, 8'h00, 1'b0},
        '{mfb_pkg::OP_BITMAP, 8'd0,   8'd0,   1'b0, 8'hff, 10'd0,    1, 8'h00, 1'b1},
        '{mfb_pkg::OP_PIXEL,  8'd127, 8'd63,  1'b1, 8'h00, 10'd0,    0, 8'h00, 1'b0},
        '{mfb_pkg::OP_READ,   8'd0,   8'd0,   1'b0, 8'h00, 10'd1023, 1, 8'h80, 1'b0},
        '{mfb_pkg::OP_PIXEL,  8'd0,   8'd0,   1'b1, 8'h00, 10'd0,    0, 8'h00, 1'b0},
        '{mfb_pkg::OP_READ,   8'd0,   8'd0,   1'b0, 8'h00, 10'd0,    1, 8'h01, 1'b0},
        '{mfb_pkg::OP_PIXEL,  8'd128, 8'd0,   1'b1, 8'h00, 10'd0,    0, 8'h00, 1'b0},
        '{mfb_pkg::OP_PIXEL,  8'd255, 8'd255, 1'b1, 8'h00, 10'd0,    0, 8'h00, 1'b0},
        '{mfb_pkg::OP_PIXEL,  8'd0,   8'd64,  1'b1, 8'h00, 10'd0,    0, 8'h00, 1'b0},
        '{mfb_pkg::OP_READ,   8'd0,   8'd0,   1'b0, 8'h00, 10'd0,    1, 8'h01, 1'b0},
        '{mfb_pkg::OP_PIXEL,  8'd127, 8'd63,  1'b0, 8'h00, 10'd0,    0, 8'h00, 1'b0},
        '{mfb_pkg::OP_READ,   8'd0,   8'd0,   1'b0, 8'h00, 10'd1023, 1, 8'h00, 1'b0},
        '{mfb_pkg::OP_CLEAR,  8'd0,   8'd0,   1'b0, 8'h00, 10'd0,    0, 8'h00, 1'b0},
        '{mfb_pkg::OP_READ,   8'd0,   8'd0,   1'b0, 8'h00, 10'd0,    1, 8'h00, 1'b0}
    };

    // Blit at (-3, 5), 10 x 2: two bytes a row, padding bits skipped, clear mid-blit.
    t_row blit_rows [] = '{
        '{mfb_pkg::OP_BITMAP, 8'd0, 8'd0, 1'b0, 8'hff, 10'd0, 0, 8'h00, 1'b0},
        '{mfb_pkg::OP_BITMAP, 8'd0, 8'd0, 1'b0, 8'hff, 10'd0, 0, 8'h00, 1'b0},
        '{mfb_pkg::OP_CLEAR,  8'd0, 8'd0, 1'b0, 8'h00, 10'd0, 0, 8'h00, 1'b0},
        '{mfb_pkg::OP_BITMAP, 8'd0, 8'd0, 1'b0, 8'haa, 10'd0, 0, 8'h00, 1'b0},
        '{mfb_pkg::OP_BITMAP, 8'd0, 8'd0, 1'b0, 8'hff, 10'd0, 1, 8'h00, 1'b1},
        '{mfb_pkg::OP_READ,   8'd0, 8'd0, 1'b0, 8'h00, 10'd0, 0, 8'h00, 1'b0},
        '{mfb_pkg::OP_READ,   8'd0, 8'd0, 1'b0, 8'h00, 10'd5, 0, 8'h00, 1'b0},
        '{mfb_pkg::OP_READ,   8'd0, 8'd0, 1'b0, 8'h00, 10'd6, 0, 8'h00, 1'b0}
    };

    initial begin
        int phase, x, y, w, h, nbytes, burst_left;
        bit c;
        t_row r;
        foreach (fb_mirror[a]) fb_mirror[a] = 8'h00;
        pos_x = '0;
        pos_y = '0;
        bm_width = '0;
        bm_height = '0;
        bm_color = 1'b1;
        col_byte = 0;
        bm_row = 0;
        rx_mode = 0;
        long_hold_req = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (reset_rows[k]) send_item(reset_rows[k]);
        drain();
        setup_blit(-3, 5, 10, 2, 1'b1);
        foreach (blit_rows[k]) send_item(blit_rows[k]);
        drain();

        burst_left = 0;
        phase = 0;
        while (n_items < RANDOM_ITEMS + 23) begin
            c = 1'($urandom);
            case (phase)
                0: begin x = 0;    y = 0;    w = 8;   h = 8;   c = 1; end
                1: begin x = -256; y = -256; w = 255; h = 2;   end
                2: begin x = 255;  y = 255;  w = 1;   h = 255; end
                3: begin x = 120;  y = 60;   w = 16;  h = 8;   end
                4: begin x = -5;   y = -3;   w = 20;  h = 12;  c = 0; end
                5: begin x = 10;   y = 10;   w = 0;   h = 5;   end
                6: begin x = 10;   y = 10;   w = 9;   h = 0;   end
                default: begin
                    if ($urandom_range(0, 7) == 0) begin
                        x = $urandom_range(0, 511) - 256;
                        y = $urandom_range(0, 511) - 256;
                    end else begin
                        x = $urandom_range(0, 156) - 16;
                        y = $urandom_range(0, 86) - 16;
                    end
                    w = $urandom_range(1, 40);
                    h = $urandom_range(1, 16);
                end
            endcase
            setup_blit(x, y, w, h, c);
            rx_mode = phase % 3;
            sender_steady = (phase % 4 == 1);
            if (phase == 4) long_hold_req = 1;

            nbytes = (w == 0 || h == 0) ? $urandom_range(1, 4) : ((w + 7) / 8) * h;
            // Now and then the blit is cut short; the next register write restarts it.
            if (phase > 6 && $urandom_range(0, 5) == 0) nbytes = $urandom_range(1, nbytes);
            for (int b = 0; b < nbytes; b++) begin
                if ($urandom_range(0, 4) == 0) begin
                    case ($urandom_range(0, 40))
                        0:       r = noise_row(mfb_pkg::OP_CLEAR);
                        1, 2, 3, 4, 5, 6, 7, 8, 9, 10: r = noise_row(mfb_pkg::OP_PIXEL);
                        default: r = noise_row(mfb_pkg::OP_READ);
                    endcase
                    b--;
                end else begin
                    r = noise_row(mfb_pkg::OP_BITMAP);
                end
                if (!sender_steady) begin
                    if (burst_left == 0) begin
                        sender_gap($urandom_range(1, 6));
                        burst_left = $urandom_range(1, 20);
                    end
                    burst_left--;
                end
                send_item(r);
            end
            for (int k = 0; k < 16; k++) send_item(noise_row(mfb_pkg::OP_READ));
            drain();
            phase++;
        end

        drain();
        $display("Covered %0d items over %0d blit settings: %0d results checked, %0d bitmaps finished.",
                 n_items, phase + 2, n_results, n_blits);
        if (n_errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
